// File: rtl/core/gsbc_pkg.sv
// Shared types and constants of the gyro still-bias calibrator.
`timescale 1ns / 1ps

package gsbc_pkg;

    // Fixed field widths
    localparam int TIME_W    = 32;
    localparam int TOL_W     = 15;
    localparam int WIN_W     = 24;
    localparam int ERR_W     = 8;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'd1;

    // Register reset values
    localparam logic [TOL_W-1:0] TOL_RESET = 15'd102;
    localparam logic [WIN_W-1:0] WIN_RESET = 24'd3000000;

    // Calibration phase
    typedef enum logic [1:0] {
        PH_ARMED   = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_EVAL = 3'd1,
        ST_ACC  = 3'd2,
        ST_PREP = 3'd3,
        ST_DIV  = 3'd4,
        ST_FIN  = 3'd5,
        ST_OUT  = 3'd6
    } t_state;

endpackage

// File: rtl/core/gyro_still_bias_calibrator.sv
// Gyro still-bias calibrator: still detection, bit-serial sums and bit-serial divide.
`timescale 1ns / 1ps

// Averages three-axis gyro samples taken while the sensor is still and reports the
// averages as the zero-rate bias. The block works on one item at a time. A gyro sample
// that is still is added into the three axis sums by bit-serial adders, one bit per
// cycle, before its result is produced. The sample that closes the window is then
// divided: three restoring dividers produce the quotients one bit per cycle over the
// same word length. Restarts, failed reads, samples that are not still and samples
// after calibration is done skip the serial add and divide.
// A finished result waits in an output register, and the next item is accepted
// while it waits.
module gyro_still_bias_calibrator #(
    parameter int COUNT_BITS = 20,
    parameter int RATE_BITS  = 16,
    localparam int IN_DATA_W  = ((gsbc_pkg::TIME_W + 3 * RATE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((3 * RATE_BITS + COUNT_BITS + gsbc_pkg::ERR_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [gsbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gsbc_pkg::WIN_W-1:0]     i_cfg_data,
    // input items
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [IN_DATA_W-1:0]           i_s_tdata,   // now_us, rate_x, rate_y, rate_z, pad
    input  logic [1:0]                     i_s_tuser,   // operation, read_ok
    // result items
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [OUT_DATA_W-1:0]          o_m_tdata,   // bias_x, bias_y, bias_z,
                                                        // still_count, errors_seen, pad
    output logic [0:0]                     o_m_tuser    // done_res
);

    import gsbc_pkg::*;

    localparam int SUM_W    = RATE_BITS + COUNT_BITS;
    localparam int BCNT_W   = $clog2(SUM_W);
    localparam int CMP_W    = (RATE_BITS > TOL_W) ? RATE_BITS : TOL_W;
    localparam logic [BCNT_W-1:0] BIT_LAST = BCNT_W'(SUM_W - 1);

    // configuration
    logic [TOL_W-1:0]      r_tol;
    logic [WIN_W-1:0]      r_win_len;

    // sequencer
    t_state                r_state, n_state;

    // calibration state
    t_phase                r_phase;
    logic [TIME_W-1:0]     r_win_start;
    logic [SUM_W-1:0]      r_sum [3];
    logic [COUNT_BITS-1:0] r_count;
    logic [RATE_BITS-1:0]  r_bias [3];
    logic [ERR_W-1:0]      r_err;

    // held item and serial datapath
    logic                  r_op;
    logic                  r_ok;
    logic [TIME_W-1:0]     r_now;
    logic [SUM_W-1:0]      r_add [3];
    logic [2:0]            r_cy;
    logic [COUNT_BITS-1:0] r_rem [3];
    logic [2:0]            r_neg;
    logic                  r_finish;
    logic [BCNT_W-1:0]     r_bit_cnt;

    // output register
    logic                  r_out_valid;
    logic                  r_out_done;
    logic [RATE_BITS-1:0]  r_out_bias [3];
    logic [COUNT_BITS-1:0] r_out_count;
    logic [ERR_W-1:0]      r_out_err;

    // combinational helpers
    logic [RATE_BITS-1:0]  mag [3];
    logic                  still;
    logic [TIME_W-1:0]     ws;
    logic [TIME_W-1:0]     elapsed;
    logic                  late;
    logic [COUNT_BITS-1:0] n_count;
    logic                  s_accept;
    logic                  out_load;
    logic                  bit_last;
    logic                  go_acc;

    // Still test, window timing and next count from the held item
    always_comb begin
        still = 1'b1;
        for (int i = 0; i < 3; i++) begin
            mag[i] = r_add[i][RATE_BITS-1] ? -r_add[i][RATE_BITS-1:0]
                                           : r_add[i][RATE_BITS-1:0];
            if (!(CMP_W'(mag[i]) < CMP_W'(r_tol))) begin
                still = 1'b0;
            end
        end
        ws      = (r_phase == PH_ARMED) ? r_now : r_win_start;
        elapsed = r_now - ws;
        late    = elapsed > TIME_W'(r_win_len);
        n_count = r_count + COUNT_BITS'(1);
    end

    assign s_accept = i_s_tvalid && o_s_tready;
    assign bit_last = (r_bit_cnt == BIT_LAST);
    assign go_acc   = !r_op && r_ok && (r_phase != PH_DONE) && still;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = go_acc ? ST_ACC : ST_OUT;
            end
            ST_ACC: begin
                if (bit_last) begin
                    n_state = r_finish ? ST_PREP : ST_OUT;
                end
            end
            ST_PREP: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (bit_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= TOL_RESET;
            r_win_len <= WIN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TOLERANCE: r_tol     <= i_cfg_data[TOL_W-1:0];
                CFG_WINDOW:    r_win_len <= i_cfg_data;
                default:       r_tol     <= r_tol;
            endcase
        end
    end

    // Calibration state and serial datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ARMED;
            r_win_start <= '0;
            r_count     <= '0;
            r_err       <= '0;
            r_bit_cnt   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i]  <= '0;
                r_bias[i] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    // capture the item, rates sign-extended for the serial adder
                    if (s_accept) begin
                        r_op  <= i_s_tuser[0];
                        r_ok  <= i_s_tuser[1];
                        r_now <= i_s_tdata[TIME_W-1:0];
                        for (int i = 0; i < 3; i++) begin
                            r_add[i] <= SUM_W'($signed(
                                i_s_tdata[TIME_W + i*RATE_BITS +: RATE_BITS]));
                        end
                    end
                end
                ST_EVAL: begin
                    priority if (r_op) begin
                        // restart: clear sums, count and bias
                        r_count <= '0;
                        r_phase <= PH_ARMED;
                        for (int i = 0; i < 3; i++) begin
                            r_sum[i]  <= '0;
                            r_bias[i] <= '0;
                        end
                    end else if (!r_ok) begin
                        r_err <= r_err + ERR_W'(1);
                    end else if (r_phase == PH_DONE) begin
                        r_err <= r_err;
                    end else if (!still) begin
                        // motion: restart the window here
                        r_count     <= '0;
                        r_win_start <= r_now;
                        r_phase     <= PH_COLLECT;
                        for (int i = 0; i < 3; i++) begin
                            r_sum[i] <= '0;
                        end
                    end else begin
                        r_win_start <= ws;
                        r_phase     <= PH_COLLECT;
                        r_count     <= n_count;
                        r_finish    <= late || (&n_count);
                        r_bit_cnt   <= '0;
                        r_cy        <= '0;
                    end
                end
                ST_ACC: begin
                    // one bit per axis per cycle, LSB first, sums rotate back in place
                    for (int i = 0; i < 3; i++) begin
                        r_sum[i] <= {r_sum[i][0] ^ r_add[i][0] ^ r_cy[i],
                                     r_sum[i][SUM_W-1:1]};
                        r_cy[i]  <= (r_sum[i][0] & r_add[i][0]) |
                                    (r_sum[i][0] & r_cy[i]) |
                                    (r_add[i][0] & r_cy[i]);
                        r_add[i] <= {r_add[i][SUM_W-1], r_add[i][SUM_W-1:1]};
                    end
                    r_bit_cnt <= r_bit_cnt + BCNT_W'(1);
                end
                ST_PREP: begin
                    // sums become dividend magnitudes; signs kept for the quotient
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= r_sum[i][SUM_W-1];
                        r_sum[i] <= r_sum[i][SUM_W-1] ? -r_sum[i] : r_sum[i];
                        r_rem[i] <= '0;
                    end
                    r_bit_cnt <= '0;
                end
                ST_DIV: begin
                    // restoring divide, MSB first; quotient bits shift in at the bottom
                    for (int i = 0; i < 3; i++) begin
                        logic [COUNT_BITS:0] trial;
                        logic [COUNT_BITS:0] diff;
                        logic                ge;
                        trial = {r_rem[i], r_sum[i][SUM_W-1]};
                        diff  = trial - {1'b0, r_count};
                        ge    = trial >= {1'b0, r_count};
                        r_rem[i] <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                        r_sum[i] <= {r_sum[i][SUM_W-2:0], ge};
                    end
                    r_bit_cnt <= r_bit_cnt + BCNT_W'(1);
                end
                ST_FIN: begin
                    for (int i = 0; i < 3; i++) begin
                        r_bias[i] <= r_neg[i] ? -r_sum[i][RATE_BITS-1:0]
                                              : r_sum[i][RATE_BITS-1:0];
                    end
                    r_phase <= PH_DONE;
                end
                ST_OUT: begin
                    r_bit_cnt <= '0;
                end
                default: begin
                    r_bit_cnt <= '0;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_done  <= (r_phase == PH_DONE);
            r_out_count <= r_count;
            r_out_err   <= r_err;
            for (int i = 0; i < 3; i++) begin
                r_out_bias[i] <= r_bias[i];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_done;
    assign o_m_tdata  = OUT_DATA_W'({r_out_err, r_out_count,
                                     r_out_bias[2], r_out_bias[1], r_out_bias[0]});

    // Assertions
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP || r_state == ST_DIV) |-> r_count != '0)
        else $error("divide started with a zero count");

    a_serial_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC || r_state == ST_DIV) |-> r_phase == PH_COLLECT)
        else $error("serial work outside the collect phase");

    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tdata[3*RATE_BITS +: COUNT_BITS] != '0)
        else $error("done reported with no still samples");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC && !bit_last) |=> r_state == ST_ACC)
        else $error("serial add left early");

    a_load_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_m_tvalid && r_state == ST_IDLE))
        else $error("result load did not return to idle");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the gyro still-bias calibrator.
`timescale 1ns / 1ps

module tb_top;
    import gsbc_pkg::*;

    localparam int  CYCLE_LIMIT     = 1_000_000;
    localparam int  HOLD_CYCLES     = 300;
    localparam int  RUN_ITEMS       = 56;
    localparam int  RUN_COUNT       = 9;
    localparam int  COUNT_FULL      = (1 << 20) - 1;
    localparam bit  OP_SAMPLE       = 1'b0;
    localparam bit  OP_RESTART      = 1'b1;

    // One input item and one result item
    typedef struct {
        logic               op;
        logic               read_ok;
        logic [31:0]        now_us;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } t_gyro_item;

    typedef struct {
        logic               done;
        logic signed [15:0] bias_x;
        logic signed [15:0] bias_y;
        logic signed [15:0] bias_z;
        logic [19:0]        still_n;
        logic [7:0]         err_n;
    } t_cal_result;

    // Directed row: expected result typed in only where it is obvious
    typedef struct {
        t_gyro_item  it;
        bit          typed;
        t_cal_result want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [0:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [79:0] i_s_tdata;     // now_us, rate_x, rate_y, rate_z
    logic [1:0]  i_s_tuser;     // operation, read_ok
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [79:0] o_m_tdata;     // bias_x, bias_y, bias_z, still_count, errors_seen, pad
    logic [0:0]  o_m_tuser;     // done_res

    gyro_still_bias_calibrator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // Calibrator mirror state
    t_phase             cal_phase;
    logic [31:0]        win_open_us;
    longint             axis_total [3];
    int unsigned        still_cnt;
    logic signed [15:0] bias_hold [3];
    logic [7:0]         read_errs;
    logic [14:0]        tol_cfg;
    logic [23:0]        win_cfg;

    t_cal_result bias_expect_q [$];
    t_dir_row    dir_rows [$];

    int  fail_n;
    int  items_sent;
    int  results_seen;
    int  calibrations;
    int  settings_used;
    int  cycle_n;
    bit  no_idle;
    bit  hold_off_req;
    int  stall_left;

    // Clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_n);
            $display("gyro_still_bias_calibrator test failed");
            $finish;
        end
    end

    // Advance the mirror by one accepted item, return the result it causes
    function automatic t_cal_result calc_calibration(input t_gyro_item it);
        t_cal_result        res;
        logic signed [15:0] rate [3];
        logic [31:0]        elapsed;
        bit                 calm;
        int                 lim;
        rate[0] = it.rate_x;
        rate[1] = it.rate_y;
        rate[2] = it.rate_z;
        lim     = int'(tol_cfg);
        calm    = 1'b1;
        if (it.op == OP_RESTART) begin
            for (int i = 0; i < 3; i++) begin
                axis_total[i] = 0;
                bias_hold[i]  = '0;
            end
            still_cnt = 0;
            cal_phase = PH_ARMED;
        end else if (!it.read_ok) begin
            read_errs = read_errs + 8'd1;
        end else if (cal_phase != PH_DONE) begin
            if (cal_phase == PH_ARMED) begin
                win_open_us = it.now_us;
                cal_phase   = PH_COLLECT;
            end
            for (int i = 0; i < 3; i++)
                if (!(int'(rate[i]) > -lim && int'(rate[i]) < lim))
                    calm = 1'b0;
            if (!calm) begin
                // motion: drop the window and reopen it here
                for (int i = 0; i < 3; i++)
                    axis_total[i] = 0;
                still_cnt   = 0;
                win_open_us = it.now_us;
            end else begin
                still_cnt++;
                for (int i = 0; i < 3; i++)
                    axis_total[i] += longint'(rate[i]);
                elapsed = it.now_us - win_open_us;
                if (elapsed > {8'd0, win_cfg} || still_cnt >= COUNT_FULL) begin
                    // signed divide truncates toward zero
                    for (int i = 0; i < 3; i++)
                        bias_hold[i] = 16'(axis_total[i] / longint'(still_cnt));
                    cal_phase = PH_DONE;
                    calibrations++;
                end
            end
        end
        res.done    = (cal_phase == PH_DONE);
        res.bias_x  = bias_hold[0];
        res.bias_y  = bias_hold[1];
        res.bias_z  = bias_hold[2];
        res.still_n = still_cnt[19:0];
        res.err_n   = read_errs;
        return res;
    endfunction

    function automatic void add_row(input logic op, input logic ok, input logic [31:0] now,
                                    input int x, input int y, input int z, input bit typed,
                                    input logic done, input int cnt, input int errs);
        t_dir_row row;
        row.it.op          = op;
        row.it.read_ok     = ok;
        row.it.now_us      = now;
        row.it.rate_x      = 16'(x);
        row.it.rate_y      = 16'(y);
        row.it.rate_z      = 16'(z);
        row.typed          = typed;
        row.want.done      = done;
        row.want.bias_x    = '0;
        row.want.bias_y    = '0;
        row.want.bias_z    = '0;
        row.want.still_n   = 20'(cnt);
        row.want.err_n     = 8'(errs);
        dir_rows.push_back(row);
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Rate strictly inside the current tolerance, or zero when the tolerance is zero
    function automatic logic signed [15:0] calm_rate();
        int lim;
        lim = int'(tol_cfg);
        if (lim == 0)
            return '0;
        return 16'($urandom_range(0, 2 * lim - 2) - (lim - 1));
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_n++;
        end
    endfunction

    // Offer one item, record its expected result when it is taken
    task automatic send_item(input t_gyro_item it, input bit typed, input t_cal_result want);
        int          gap;
        t_cal_result pred;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = {it.rate_z, it.rate_y, it.rate_x, it.now_us};
        i_s_tuser  = {it.read_ok, it.op};
        i_s_tvalid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        pred = calc_calibration(it);
        bias_expect_q.push_back(typed ? want : pred);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Let every result drain so the block is idle
    task automatic drain();
        i_s_tvalid = 1'b0;
        while (bias_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [0:0] index, input logic [23:0] value);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        if (index == CFG_TOLERANCE)
            tol_cfg = value[14:0];
        else
            win_cfg = value[23:0];
    endtask

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_cal_result got;
        t_cal_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.done    = o_m_tuser[0];
            got.bias_x  = o_m_tdata[15:0];
            got.bias_y  = o_m_tdata[31:16];
            got.bias_z  = o_m_tdata[47:32];
            got.still_n = o_m_tdata[67:48];
            got.err_n   = o_m_tdata[75:68];
            results_seen++;
            if (bias_expect_q.size() == 0) begin
                $error("unexpected result item, none pending");
                fail_n++;
            end else begin
                want = bias_expect_q.pop_front();
                check_field("done_res", want.done, got.done);
                check_field("bias_x", want.bias_x, got.bias_x);
                check_field("bias_y", want.bias_y, got.bias_y);
                check_field("bias_z", want.bias_z, got.bias_z);
                check_field("still_count", want.still_n, got.still_n);
                check_field("errors_seen", want.err_n, got.err_n);
            end
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_tready   = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else begin
                i_m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus
    initial begin
        t_gyro_item  it;
        t_cal_result none;
        logic [31:0] now_clk;
        int unsigned step_max;
        int          pick;
        logic [14:0] tol_set [RUN_COUNT];
        logic [23:0] win_set [RUN_COUNT];

        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = CFG_TOLERANCE;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        cycle_n      = 0;
        fail_n       = 0;
        items_sent   = 0;
        results_seen = 0;
        calibrations = 0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        none         = '{default: '0};

        // Mirror state after reset
        cal_phase   = PH_ARMED;
        win_open_us = '0;
        still_cnt   = 0;
        read_errs   = '0;
        tol_cfg     = TOL_RESET;
        win_cfg     = WIN_RESET;
        settings_used = 1;
        for (int i = 0; i < 3; i++) begin
            axis_total[i] = 0;
            bias_hold[i]  = '0;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at reset settings (tolerance 102, window 3000000 us)
        add_row(OP_SAMPLE,  1'b0, 32'h0000_0000, 0, 0, 0, 1, 1'b0, 0, 1);       // failed read
        add_row(OP_RESTART, 1'b0, 32'hFFFF_FFFF, -32768, -32768, -32768, 1, 1'b0, 0, 1);
        add_row(OP_SAMPLE,  1'b1, 32'hFFFF_FF00, 101, -101, 0, 1, 1'b0, 1, 1);  // opens window
        add_row(OP_SAMPLE,  1'b1, 32'hFFFF_FF10, 102, 0, 0, 1, 1'b0, 0, 1);     // at +tol
        add_row(OP_SAMPLE,  1'b1, 32'hFFFF_FF20, 0, -102, 0, 1, 1'b0, 0, 1);    // at -tol
        add_row(OP_SAMPLE,  1'b1, 32'hFFFF_FF30, 32767, -32768, 0, 1, 1'b0, 0, 1);
        add_row(OP_SAMPLE,  1'b1, 32'hFFFF_FF40, 0, 0, -32768, 1, 1'b0, 0, 1);
        add_row(OP_SAMPLE,  1'b1, 32'hFFFF_FF50, 10, -20, 30, 0, 1'b0, 0, 0);
        add_row(OP_SAMPLE,  1'b0, 32'hFFFF_FF60, 7, 7, 7, 0, 1'b0, 0, 0);
        add_row(OP_SAMPLE,  1'b1, 32'h0000_0010, -11, 21, -31, 0, 1'b0, 0, 0);  // across wrap
        add_row(OP_SAMPLE,  1'b1, 32'd3000000, -100, 50, 7, 0, 1'b0, 0, 0);     // window ends
        add_row(OP_SAMPLE,  1'b1, 32'd3000100, 100, 100, 100, 0, 1'b0, 0, 0);   // ignored
        add_row(OP_SAMPLE,  1'b0, 32'd3000200, 0, 0, 0, 0, 1'b0, 0, 0);         // counted
        add_row(OP_RESTART, 1'b1, 32'd3000300, 5, 5, 5, 1, 1'b0, 0, 3);
        add_row(OP_SAMPLE,  1'b1, 32'd1000, 1, 1, 1, 0, 1'b0, 0, 0);
        add_row(OP_SAMPLE,  1'b1, 32'd3001000, -1, -1, -1, 0, 1'b0, 0, 0);      // exactly length
        add_row(OP_SAMPLE,  1'b1, 32'd3001001, -5, 3, 0, 0, 1'b0, 0, 0);        // one past
        add_row(OP_RESTART, 1'b0, 32'd3001002, 0, 0, 0, 1, 1'b0, 0, 3);

        foreach (dir_rows[k])
            send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);

        // Random runs, each at its own register setting
        tol_set = '{15'd0, 15'd32767, 15'd32767, 15'd1, 15'd102, 15'd0, 15'd0, 15'd0, 15'd32767};
        win_set = '{24'd0, 24'd0, 24'hFF_FFFF, 24'd50, 24'd3000000, 24'd0, 24'd0, 24'd0, 24'd1};
        for (int p = 5; p < 8; p++) begin
            tol_set[p] = 15'($urandom_range(2, 3000));
            win_set[p] = 24'($urandom_range(1, 20000));
        end
        now_clk = $urandom;

        for (int p = 0; p < RUN_COUNT; p++) begin
            drain();
            no_idle = (p % 3 == 2);
            set_reg(CFG_TOLERANCE, {9'd0, tol_set[p]});
            set_reg(CFG_WINDOW, win_set[p]);
            settings_used++;
            step_max = (win_set[p] / 16 > 0) ? win_set[p] / 16 : 1;
            // long result-side hold-off while items keep coming
            if (p == 1)
                hold_off_req = 1'b1;
            for (int n = 0; n < RUN_ITEMS; n++) begin
                pick    = $urandom_range(0, 99);
                now_clk = now_clk + $urandom_range(0, step_max);
                if ($urandom_range(0, 49) == 0)
                    now_clk = $urandom;
                it.op      = OP_SAMPLE;
                it.read_ok = 1'b1;
                it.now_us  = now_clk;
                it.rate_x  = 16'($urandom);
                it.rate_y  = 16'($urandom);
                it.rate_z  = 16'($urandom);
                if ((cal_phase == PH_DONE && pick < 60) || pick < 5) begin
                    it.op      = OP_RESTART;
                    it.read_ok = $urandom_range(0, 1);
                end else if (pick < 13) begin
                    it.read_ok = 1'b0;
                end else if (pick < 25) begin
                    // motion or noise; some sit exactly on the tolerance
                    if (pick < 18)
                        it.rate_y = $urandom_range(0, 1) ? 16'(tol_cfg) : -16'(tol_cfg);
                end else begin
                    it.rate_x = calm_rate();
                    it.rate_y = calm_rate();
                    it.rate_z = calm_rate();
                end
                send_item(it, 1'b0, none);
            end
        end

        // Wind down
        i_s_tvalid = 1'b0;
        while (bias_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("Covered %0d items, %0d results checked, %0d bias calibrations completed",
                 items_sent, results_seen, calibrations);
        $display("over %0d register settings with random gaps, stalls and one long hold-off",
                 settings_used);
        if (fail_n == 0)
            $display("gyro_still_bias_calibrator test passed");
        else
            $display("gyro_still_bias_calibrator test failed");
        $finish;
    end

endmodule
